// ===== src/assert_macros.svh =====
// Shared assertion macros. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/rnp_pkg.sv =====
package rnp_pkg;

    // field widths
    localparam int ID_BITS       = 20;
    localparam int COORD_BITS    = 24;
    localparam int DIR_BITS      = 16;
    localparam int SIZE_BITS     = COORD_BITS - 1;
    localparam int MODE_BITS     = 3;
    localparam int CFG_REGS      = 8;
    localparam int CFG_IDX_BITS  = $clog2(CFG_REGS);
    localparam int CFG_DATA_BITS = COORD_BITS;

    // datapath widths
    localparam int V_BITS     = COORD_BITS + 1;
    localparam int S_BITS     = COORD_BITS;
    localparam int PROD_BITS  = V_BITS + DIR_BITS;
    localparam int DOT_BITS   = PROD_BITS + 2;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int MAG_BITS   = CROSS_BITS;
    localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
    localparam int HIGH_BITS  = MAG_BITS - HALF_BITS;
    localparam int CSQ_BITS   = 2 * MAG_BITS;
    localparam int PERP_BITS  = CSQ_BITS + 2;
    localparam int VSQ_BITS   = 2 * V_BITS;
    localparam int DIST_BITS  = VSQ_BITS + 2;
    localparam int SSQ_BITS   = 2 * S_BITS;
    localparam int SSQ_HALF   = SSQ_BITS / 2;
    localparam int DD_BITS    = 2 * DIR_BITS;
    localparam int THR_BITS   = SSQ_BITS + DD_BITS;
    localparam int CMP_BITS   = PERP_BITS;

    // front-to-back queue
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_RADIUS   = 3'd6,
        CFG_MODE     = 3'd7
    } cfg_idx_t;

    // mode_flags layout
    localparam int MODE_NEAR_BIT = 1;
    localparam int MODE_INCL_BIT = 2;
    localparam logic [1:0] MODE_LIST = 2'd1;

    typedef enum logic {
        KIND_MEMBER = 1'b0,
        KIND_FINAL  = 1'b1
    } kind_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [DIR_BITS-1:0]   dir_x;
        logic signed [DIR_BITS-1:0]   dir_y;
        logic signed [DIR_BITS-1:0]   dir_z;
        logic [SIZE_BITS-1:0]         radius;
        logic [MODE_BITS-1:0]         mode;
    } cfg_t;

    localparam logic [DIR_BITS-1:0] DIR_Z_RESET = DIR_BITS'(1) << (DIR_BITS - 2);

    localparam cfg_t CFG_RESET = '{
        origin_x: '0, origin_y: '0, origin_z: '0,
        dir_x: '0, dir_y: '0, dir_z: DIR_Z_RESET,
        radius: '0, mode: '0
    };

    // one classified node as it waits for the back end
    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic signed [V_BITS-1:0] vx;
        logic signed [V_BITS-1:0] vy;
        logic signed [V_BITS-1:0] vz;
        logic [S_BITS-1:0]        size_sum;
        logic                     skip;
        logic                     last;
    } item_t;

endpackage

// ===== src/rnp_front.sv =====
module rnp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rnp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rnp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rnp_pkg::ID_BITS-1:0]       node_id,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_y,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_z,
    input  logic [rnp_pkg::SIZE_BITS-1:0]     node_size,
    input  logic                              unhighlighted,
    input  logic                              last_node,
    input  logic                              q_full,
    output logic                              q_push,
    output rnp_pkg::item_t                    q_item,
    output rnp_pkg::cfg_t                     cfg
);
    import rnp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X: cfg_next.origin_x = cfg_data[COORD_BITS-1:0];
                CFG_ORIGIN_Y: cfg_next.origin_y = cfg_data[COORD_BITS-1:0];
                CFG_ORIGIN_Z: cfg_next.origin_z = cfg_data[COORD_BITS-1:0];
                CFG_DIR_X:    cfg_next.dir_x    = cfg_data[DIR_BITS-1:0];
                CFG_DIR_Y:    cfg_next.dir_y    = cfg_data[DIR_BITS-1:0];
                CFG_DIR_Z:    cfg_next.dir_z    = cfg_data[DIR_BITS-1:0];
                CFG_RADIUS:   cfg_next.radius   = cfg_data[SIZE_BITS-1:0];
                CFG_MODE:     cfg_next.mode     = cfg_data[MODE_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // accept while the queue has room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // offset from the ray origin, sign-extended by one bit
    always_comb
    begin
        q_item.id       = node_id;
        q_item.vx       = {pos_x[COORD_BITS-1], pos_x}
                        - {cfg_reg.origin_x[COORD_BITS-1], cfg_reg.origin_x};
        q_item.vy       = {pos_y[COORD_BITS-1], pos_y}
                        - {cfg_reg.origin_y[COORD_BITS-1], cfg_reg.origin_y};
        q_item.vz       = {pos_z[COORD_BITS-1], pos_z}
                        - {cfg_reg.origin_z[COORD_BITS-1], cfg_reg.origin_z};
        q_item.size_sum = {1'b0, cfg_reg.radius} + {1'b0, node_size};
        q_item.skip     = unhighlighted && !cfg_reg.mode[MODE_INCL_BIT];
        q_item.last     = last_node;
    end

endmodule

// ===== src/rnp_queue.sv =====
module rnp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rnp_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output rnp_pkg::item_t head_item
);
    import rnp_pkg::*;

    item_t                slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full       = (count_reg == QCNT_BITS'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/rnp_back.sv =====
`include "assert_macros.svh"

module rnp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rnp_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  rnp_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        result_kind,
    output logic [rnp_pkg::ID_BITS-1:0] result_id,
    output logic                        found,
    output logic                        last
);
    import rnp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_SUM1 = 9'b000000100,
        ST_ABS  = 9'b000001000,
        ST_MUL2 = 9'b000010000,
        ST_SUM2 = 9'b000100000,
        ST_SUM3 = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_UPD  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fin_reg;
    logic   fin_next;

    item_t item_reg;

    logic signed [V_BITS-1:0]   v_s [3];
    logic signed [DIR_BITS-1:0] d_s [3];

    // first products
    logic signed [PROD_BITS-1:0] dot_reg [3];
    logic signed [PROD_BITS-1:0] dot_next [3];
    logic signed [PROD_BITS-1:0] cra_reg [3];
    logic signed [PROD_BITS-1:0] cra_next [3];
    logic signed [PROD_BITS-1:0] crb_reg [3];
    logic signed [PROD_BITS-1:0] crb_next [3];
    logic signed [VSQ_BITS-1:0]  vsq_reg [3];
    logic signed [VSQ_BITS-1:0]  vsq_next [3];
    logic signed [DD_BITS-1:0]   dsq_reg [3];
    logic signed [DD_BITS-1:0]   dsq_next [3];
    logic [SSQ_BITS-1:0]         ssq_reg;
    logic [SSQ_BITS-1:0]         ssq_next;

    // first sums
    logic signed [DOT_BITS-1:0]   t_reg;
    logic signed [DOT_BITS-1:0]   t_next;
    logic signed [CROSS_BITS-1:0] c_reg [3];
    logic signed [CROSS_BITS-1:0] c_next [3];
    logic [DIST_BITS-1:0]         dist_reg;
    logic [DIST_BITS-1:0]         dist_next;
    logic [DD_BITS-1:0]           dd_reg;
    logic [DD_BITS-1:0]           dd_next;

    // magnitudes
    logic [MAG_BITS-1:0] mag_reg [3];
    logic [MAG_BITS-1:0] mag_next [3];
    logic                tpos_reg;
    logic                tpos_next;

    // split squares and threshold halves
    logic [2*HIGH_BITS-1:0]         hh_reg [3];
    logic [2*HIGH_BITS-1:0]         hh_next [3];
    logic [HIGH_BITS+HALF_BITS-1:0] hl_reg [3];
    logic [HIGH_BITS+HALF_BITS-1:0] hl_next [3];
    logic [2*HALF_BITS-1:0]         ll_reg [3];
    logic [2*HALF_BITS-1:0]         ll_next [3];
    logic [SSQ_HALF+DD_BITS-1:0]    thr_hi_reg;
    logic [SSQ_HALF+DD_BITS-1:0]    thr_hi_next;
    logic [SSQ_HALF+DD_BITS-1:0]    thr_lo_reg;
    logic [SSQ_HALF+DD_BITS-1:0]    thr_lo_next;

    logic [CSQ_BITS-1:0]  csq_reg [3];
    logic [CSQ_BITS-1:0]  csq_next [3];
    logic [THR_BITS-1:0]  thr_reg;
    logic [THR_BITS-1:0]  thr_next;
    logic [PERP_BITS-1:0] perp_reg;
    logic [PERP_BITS-1:0] perp_next;

    // decision flags
    logic member_reg;
    logic member_next;
    logic perp_lt_reg;
    logic perp_lt_next;
    logic dist_lt_reg;
    logic dist_lt_next;
    logic cand_reg;
    logic cand_next;

    // running best
    logic [CMP_BITS-1:0] best_reg;
    logic [CMP_BITS-1:0] best_next;
    logic [ID_BITS-1:0]  best_id_reg;
    logic [ID_BITS-1:0]  best_id_next;
    logic                have_best_reg;
    logic                have_best_next;
    logic                best_valid_reg;
    logic                best_valid_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;
    logic               out_free;
    kind_t              out_kind_reg;
    kind_t              out_kind_next;
    logic [ID_BITS-1:0] out_id_reg;
    logic [ID_BITS-1:0] out_id_next;
    logic               out_found_reg;
    logic               out_found_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic [1:0] mode;

    assign mode = cfg.mode[1:0];

    assign v_s[0] = item_reg.vx;
    assign v_s[1] = item_reg.vy;
    assign v_s[2] = item_reg.vz;
    assign d_s[0] = cfg.dir_x;
    assign d_s[1] = cfg.dir_y;
    assign d_s[2] = cfg.dir_z;

    // dot, cross and square terms, one multiplier each
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_next[i] = v_s[i] * d_s[i];
            vsq_next[i] = v_s[i] * v_s[i];
            dsq_next[i] = d_s[i] * d_s[i];
        end
        cra_next[0] = v_s[1] * d_s[2];
        crb_next[0] = v_s[2] * d_s[1];
        cra_next[1] = v_s[2] * d_s[0];
        crb_next[1] = v_s[0] * d_s[2];
        cra_next[2] = v_s[0] * d_s[1];
        crb_next[2] = v_s[1] * d_s[0];
        ssq_next    = item_reg.size_sum * item_reg.size_sum;
    end

    always_comb
    begin
        t_next = DOT_BITS'(dot_reg[0]) + DOT_BITS'(dot_reg[1]) + DOT_BITS'(dot_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = CROSS_BITS'(cra_reg[i]) - CROSS_BITS'(crb_reg[i]);
        end
        dist_next = DIST_BITS'($unsigned(vsq_reg[0])) + DIST_BITS'($unsigned(vsq_reg[1]))
                  + DIST_BITS'($unsigned(vsq_reg[2]));
        dd_next   = $unsigned(dsq_reg[0]) + $unsigned(dsq_reg[1]) + $unsigned(dsq_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = c_reg[i][CROSS_BITS-1] ? $unsigned(-c_reg[i]) : $unsigned(c_reg[i]);
        end
        tpos_next = !t_reg[DOT_BITS-1] && (t_reg != '0);
    end

    // squares of the wide cross terms and the threshold product, in halves
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hh_next[i] = mag_reg[i][MAG_BITS-1:HALF_BITS] * mag_reg[i][MAG_BITS-1:HALF_BITS];
            hl_next[i] = mag_reg[i][MAG_BITS-1:HALF_BITS] * mag_reg[i][HALF_BITS-1:0];
            ll_next[i] = mag_reg[i][HALF_BITS-1:0] * mag_reg[i][HALF_BITS-1:0];
        end
        thr_hi_next = ssq_reg[SSQ_BITS-1:SSQ_HALF] * dd_reg;
        thr_lo_next = ssq_reg[SSQ_HALF-1:0] * dd_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            csq_next[i] = (CSQ_BITS'(hh_reg[i]) << (2 * HALF_BITS))
                        + (CSQ_BITS'(hl_reg[i]) << (HALF_BITS + 1))
                        + CSQ_BITS'(ll_reg[i]);
        end
        thr_next  = (THR_BITS'(thr_hi_reg) << SSQ_HALF) + THR_BITS'(thr_lo_reg);
        perp_next = PERP_BITS'(csq_reg[0]) + PERP_BITS'(csq_reg[1]) + PERP_BITS'(csq_reg[2]);
    end

    always_comb
    begin
        member_next  = !(CMP_BITS'(thr_reg) < CMP_BITS'(perp_reg));
        perp_lt_next = !best_valid_reg || (CMP_BITS'(perp_reg) < best_reg);
        dist_lt_next = !best_valid_reg || (CMP_BITS'(dist_reg) < best_reg);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !fin_reg && q_valid;

    // sequencer and result logic
    always_comb
    begin
        state_next      = state_reg;
        fin_next        = fin_reg;
        cand_next       = cand_reg;
        best_next       = best_reg;
        best_id_next    = best_id_reg;
        have_best_next  = have_best_reg;
        best_valid_next = best_valid_reg;
        out_load        = 1'b0;
        out_kind_next   = KIND_MEMBER;
        out_id_next     = item_reg.id;
        out_found_next  = 1'b0;
        out_last_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fin_reg)
                begin
                    // final answer of the set, then clear the best
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_kind_next   = KIND_FINAL;
                        out_id_next     = ((mode == MODE_LIST) || !have_best_reg) ?
                                          '0 : best_id_reg;
                        out_found_next  = have_best_reg;
                        out_last_next   = 1'b1;
                        best_id_next    = '0;
                        have_best_next  = 1'b0;
                        best_valid_next = 1'b0;
                        fin_next        = 1'b0;
                    end
                end
                else if (q_valid)
                begin
                    cand_next  = 1'b0;
                    state_next = q_item.skip ? ST_UPD : ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_SUM1;
            ST_SUM1: state_next = ST_ABS;
            ST_ABS:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SUM2;
            ST_SUM2: state_next = ST_SUM3;
            ST_SUM3: state_next = ST_CMP;
            ST_CMP:
            begin
                cand_next  = tpos_reg;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    if (cand_reg)
                    begin
                        priority if (mode[MODE_NEAR_BIT])
                        begin
                            if (member_reg && dist_lt_reg)
                            begin
                                best_next       = CMP_BITS'(dist_reg);
                                best_id_next    = item_reg.id;
                                have_best_next  = 1'b1;
                                best_valid_next = 1'b1;
                            end
                        end
                        else if (mode == MODE_LIST)
                        begin
                            if (member_reg)
                            begin
                                out_load       = 1'b1;
                                have_best_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (perp_lt_reg)
                            begin
                                best_next       = CMP_BITS'(perp_reg);
                                best_id_next    = item_reg.id;
                                have_best_next  = 1'b1;
                                best_valid_next = 1'b1;
                            end
                        end
                    end
                    fin_next   = item_reg.last;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fin_reg        <= 1'b0;
            best_id_reg    <= '0;
            have_best_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_reg        <= fin_next;
            best_id_reg    <= best_id_next;
            have_best_reg  <= have_best_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers, each loaded in its own step
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_MUL1)
        begin
            dot_reg <= dot_next;
            cra_reg <= cra_next;
            crb_reg <= crb_next;
            vsq_reg <= vsq_next;
            dsq_reg <= dsq_next;
            ssq_reg <= ssq_next;
        end
        if (state_reg == ST_SUM1)
        begin
            t_reg    <= t_next;
            c_reg    <= c_next;
            dist_reg <= dist_next;
            dd_reg   <= dd_next;
        end
        if (state_reg == ST_ABS)
        begin
            mag_reg  <= mag_next;
            tpos_reg <= tpos_next;
        end
        if (state_reg == ST_MUL2)
        begin
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            ll_reg     <= ll_next;
            thr_hi_reg <= thr_hi_next;
            thr_lo_reg <= thr_lo_next;
        end
        if (state_reg == ST_SUM2)
        begin
            csq_reg <= csq_next;
            thr_reg <= thr_next;
        end
        if (state_reg == ST_SUM3)
        begin
            perp_reg <= perp_next;
        end
        if (state_reg == ST_CMP)
        begin
            member_reg  <= member_next;
            perp_lt_reg <= perp_lt_next;
            dist_lt_reg <= dist_lt_next;
        end
        cand_reg <= cand_next;
        best_reg <= best_next;
        if (out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_id_reg    <= out_id_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign result_id   = out_id_reg;
    assign found       = out_found_reg;
    assign last        = out_last_reg;

    `ASSERT_IMPLY(a_dist_has_node, clk, rst_n, best_valid_reg, have_best_reg, "kept distance without a kept node")
    `ASSERT_NEXT(a_final_clears, clk, rst_n, (state_reg == ST_IDLE) && fin_reg && out_free, !have_best_reg && !best_valid_reg && !fin_reg, "best state not cleared after final answer")
    `ASSERT_IMPLY(a_last_on_final, clk, rst_n, out_valid_reg, out_last_reg == (out_kind_reg == KIND_FINAL), "last flag does not match result kind")
    `ASSERT_IMPLY(a_no_pop_in_work, clk, rst_n, state_reg != ST_IDLE, !q_pop, "queue popped while an item is in work")

endmodule

// ===== src/ray_node_pick_unit.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// cfg       | cfg_write                  | cfg_index, cfg_data
// in        | in_valid / in_stall        | node_id, pos_x/y/z, node_size,
//           |                            | unhighlighted, last_node
// out       | out_valid / out_stall      | result_kind, result_id, found, last
//
// A node that is worked on passes the back end in this order: pop, two multiply
// steps, five add/compare steps, update; a skipped unhighlighted node goes
// from pop straight to update. A node with last_node set adds a final-answer step.
// The shared arithmetic sequencer takes one node at a time; a two-entry
// queue lets the front keep taking transfers while the back end works.
// rst_n is asynchronous, active low: it loads the register reset values and
// empties queue, sequencer and output register.
// in_stall rises only when the queue is full; the back end holds in its update
// step or final answer while out_stall keeps the output register occupied.
module ray_node_pick_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [rnp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [rnp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rnp_pkg::ID_BITS-1:0]           node_id,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_y,
    input  logic signed [rnp_pkg::COORD_BITS-1:0] pos_z,
    input  logic [rnp_pkg::SIZE_BITS-1:0]         node_size,
    input  logic                                  unhighlighted,
    input  logic                                  last_node,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  result_kind,
    output logic [rnp_pkg::ID_BITS-1:0]           result_id,
    output logic                                  found,
    output logic                                  last
);
    import rnp_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t head_item;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_valid;

    // Front: hold the ray registers, offset each node from the origin, form radius
    // plus node size and flag unhighlighted nodes to drop unless the mode includes them.
    rnp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .node_id       (node_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .node_size     (node_size),
        .unhighlighted (unhighlighted),
        .last_node     (last_node),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item),
        .cfg           (cfg)
    );

    // Queue: decouple the classify side from the arithmetic side.
    rnp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // Back: run the distance math step by step, keep the running best, and
    // advance member reports and final answers into the output register.
    rnp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .result_id   (result_id),
        .found       (found),
        .last        (last)
    );

endmodule

// ===== bench/tb_ray_node_pick_unit.sv =====
module tb_ray_node_pick_unit;
    import rnp_pkg::*;

    // Cycles to let the back end run dry once nothing more is expected
    // (two queued nodes plus the one in the sequencer).
    localparam int SETTLE_CYCLES = 40;
    // Print at most this many mismatch lines; keep counting past it.
    localparam int MAX_PRINTS    = 40;
    // Random node stream length.
    localparam int RANDOM_NODES  = 750;

    // One node as it crosses the input channel.
    typedef struct {
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic [SIZE_BITS-1:0]         size;
        logic                         unhl;
        logic                         lastn;
    } node_t;

    // One result as it crosses the output channel.
    typedef struct {
        kind_t              kind;
        logic [ID_BITS-1:0] id;
        logic               found;
        logic               last;
    } pick_t;

    // Mirror of the picking logic: register copy, running best, and the
    // queue of picks the block owes us.
    class pick_scoreboard;
        logic [CFG_DATA_BITS-1:0] regs [CFG_REGS];
        logic [127:0]             best_dist_sq;
        logic [ID_BITS-1:0]       best_node;
        bit                       have_best;
        pick_t                    picks_due [$];
        int                       errors;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            regs[CFG_DIR_Z] = CFG_DATA_BITS'(DIR_Z_RESET);
            errors = 0;
            clear_best();
        endfunction

        function void clear_best();
            best_dist_sq = '1;
            best_node    = '0;
            have_best    = 1'b0;
        endfunction

        function logic [127:0] sq(longint v);
            logic signed [127:0] w;
            w = 128'(v);
            return w * w;
        endfunction

        function int pending();
            return picks_due.size();
        endfunction

        // Append one pick to the owed list.
        function void queue_pick(pick_t p);
            picks_due = {picks_due, p};
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            regs[idx] = val;
        endfunction

        // Work out what one accepted node leaves behind on the output.
        function void note_node(node_t n);
            logic [1:0]   mode;
            bit           incl;
            bit           member;
            longint       vx, vy, vz, dx, dy, dz, t;
            logic [127:0] perp, orig_dist, thr, s, dd;
            pick_t        p;
            mode = regs[CFG_MODE][1:0];
            incl = regs[CFG_MODE][MODE_INCL_BIT];
            if (!(n.unhl && !incl)) begin
                vx = longint'(n.px) - longint'($signed(regs[CFG_ORIGIN_X]));
                vy = longint'(n.py) - longint'($signed(regs[CFG_ORIGIN_Y]));
                vz = longint'(n.pz) - longint'($signed(regs[CFG_ORIGIN_Z]));
                dx = longint'($signed(regs[CFG_DIR_X][DIR_BITS-1:0]));
                dy = longint'($signed(regs[CFG_DIR_Y][DIR_BITS-1:0]));
                dz = longint'($signed(regs[CFG_DIR_Z][DIR_BITS-1:0]));
                t  = vx * dx + vy * dy + vz * dz;
                // only nodes strictly ahead of the origin count
                if (t > 0) begin
                    perp = sq(vy * dz - vz * dy) + sq(vz * dx - vx * dz)
                         + sq(vx * dy - vy * dx);
                    s    = 128'(regs[CFG_RADIUS][SIZE_BITS-1:0]) + 128'(n.size);
                    dd   = sq(dx) + sq(dy) + sq(dz);
                    // both sides carry |d|^2, so a non-unit direction still works
                    thr    = s * s * dd;
                    member = !(thr < perp);
                    if (mode[MODE_NEAR_BIT]) begin
                        orig_dist = sq(vx) + sq(vy) + sq(vz);
                        if (member && orig_dist < best_dist_sq) begin
                            best_dist_sq = orig_dist;
                            best_node    = n.id;
                            have_best    = 1'b1;
                        end
                    end
                    else if (mode == MODE_LIST) begin
                        if (member) begin
                            p.kind  = KIND_MEMBER;
                            p.id    = n.id;
                            p.found = 1'b0;
                            p.last  = 1'b0;
                            queue_pick(p);
                            have_best = 1'b1;
                        end
                    end
                    else if (perp < best_dist_sq) begin
                        best_dist_sq = perp;
                        best_node    = n.id;
                        have_best    = 1'b1;
                    end
                end
            end
            if (n.lastn) begin
                p.kind  = KIND_FINAL;
                p.id    = (mode == MODE_LIST || !have_best) ? '0 : best_node;
                p.found = have_best;
                p.last  = 1'b1;
                queue_pick(p);
                clear_best();
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < MAX_PRINTS)
                $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        // Compare one delivered pick against the oldest one owed.
        task check_pick(pick_t got);
            pick_t want;
            if (picks_due.size() == 0) begin
                report("result with nothing pending, id", 64'(got.id), '0);
                return;
            end
            want = picks_due.pop_front();
            if (got.kind !== want.kind)
                report("result_kind", 64'(got.kind), 64'(want.kind));
            if (got.id !== want.id)
                report("result_id", 64'(got.id), 64'(want.id));
            if (got.found !== want.found)
                report("found", 64'(got.found), 64'(want.found));
            if (got.last !== want.last)
                report("last", 64'(got.last), 64'(want.last));
        endtask

        task check_drained();
            if (picks_due.size() != 0)
                report("results never delivered, count", 64'(picks_due.size()), '0);
        endtask
    endclass

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_write     = 1'b0;
    logic [CFG_IDX_BITS-1:0]      cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data      = '0;
    logic                         in_valid      = 1'b0;
    logic                         in_stall;
    logic [ID_BITS-1:0]           node_id       = '0;
    logic signed [COORD_BITS-1:0] pos_x         = '0;
    logic signed [COORD_BITS-1:0] pos_y         = '0;
    logic signed [COORD_BITS-1:0] pos_z         = '0;
    logic [SIZE_BITS-1:0]         node_size     = '0;
    logic                         unhighlighted = 1'b0;
    logic                         last_node     = 1'b0;
    logic                         out_valid;
    logic                         out_stall     = 1'b0;
    logic                         result_kind;
    logic [ID_BITS-1:0]           result_id;
    logic                         found;
    logic                         last;

    pick_scoreboard           sb;
    logic [CFG_DATA_BITS-1:0] cfg_next [CFG_REGS];
    int                       burst_left = 0;
    int                       stall_left = 0;
    bit                       idle_on    = 1'b1;

    ray_node_pick_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .node_id       (node_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .node_size     (node_size),
        .unhighlighted (unhighlighted),
        .last_node     (last_node),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .result_id     (result_id),
        .found         (found),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch all three channels at the edge; everything seen here holds its
    // pre-edge value, so the order of processes within the step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_node('{node_id, pos_x, pos_y, pos_z, node_size,
                               unhighlighted, last_node});
            if (out_valid && !out_stall)
                sb.check_pick('{kind_t'(result_kind), result_id, found, last});
        end
    end

    // Receiver: hold stall in runs of random length, stalled about a third of
    // the time; drop stall entirely while idling is off.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            stall_left = $urandom_range(1, 16);
            out_stall <= idle_on && ($urandom_range(0, 2) == 0);
        end
    end

    // Random magnitude below 2^bits with a random sign.
    function automatic longint rand_signed(int bits);
        longint m;
        m = longint'($urandom_range(0, (1 << bits) - 1));
        return ($urandom_range(0, 1) == 1) ? -m : m;
    endfunction

    // Sizes spread over every scale, full range included.
    function automatic logic [SIZE_BITS-1:0] rand_size();
        return SIZE_BITS'($urandom & ((1 << $urandom_range(0, SIZE_BITS)) - 1));
    endfunction

    function automatic void set_config(longint ox, longint oy, longint oz,
                                       longint dx, longint dy, longint dz,
                                       longint rad, longint mode);
        longint dmask;
        dmask = (longint'(1) << DIR_BITS) - 1;
        cfg_next[CFG_ORIGIN_X] = CFG_DATA_BITS'(ox);
        cfg_next[CFG_ORIGIN_Y] = CFG_DATA_BITS'(oy);
        cfg_next[CFG_ORIGIN_Z] = CFG_DATA_BITS'(oz);
        cfg_next[CFG_DIR_X]    = CFG_DATA_BITS'(dx & dmask);
        cfg_next[CFG_DIR_Y]    = CFG_DATA_BITS'(dy & dmask);
        cfg_next[CFG_DIR_Z]    = CFG_DATA_BITS'(dz & dmask);
        cfg_next[CFG_RADIUS]   = CFG_DATA_BITS'(rad);
        cfg_next[CFG_MODE]     = CFG_DATA_BITS'(mode);
    endfunction

    function automatic longint rand_origin();
        case ($urandom_range(0, 5))
            0:       return -(longint'(1) << (COORD_BITS - 1));
            1:       return (longint'(1) << (COORD_BITS - 1)) - 1;
            default: return rand_signed($urandom_range(0, 22));
        endcase
    endfunction

    function automatic longint rand_dir_extreme();
        case ($urandom_range(0, 2))
            0:       return -32768;
            1:       return 32767;
            default: return 0;
        endcase
    endfunction

    // Pick a ray: mostly unit length, sometimes axis aligned, at the
    // component extremes, or zero.
    function automatic void random_config();
        longint ox, oy, oz, dx, dy, dz, rad;
        real    rx, ry, rz, len;
        int     axis, pick;
        ox   = rand_origin();
        oy   = rand_origin();
        oz   = rand_origin();
        dx   = 0;
        dy   = 0;
        dz   = 0;
        pick = $urandom_range(0, 11);
        if (pick == 0)
        begin
            // zero direction: nothing is ever in front
        end
        else if (pick <= 2)
        begin
            dx = rand_dir_extreme();
            dy = rand_dir_extreme();
            dz = rand_dir_extreme();
        end
        else if (pick <= 6)
        begin
            axis = $urandom_range(0, 2);
            if (axis == 0)
                dx = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
            else if (axis == 1)
                dy = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
            else
                dz = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
        end
        else
        begin
            rx  = real'(int'($urandom_range(0, 32768)) - 16384);
            ry  = real'(int'($urandom_range(0, 32768)) - 16384);
            rz  = real'(int'($urandom_range(0, 32768)) - 16384);
            len = $sqrt(rx * rx + ry * ry + rz * rz);
            if (len < 1.0)
                len = 1.0;
            dx = $rtoi(rx * 16384.0 / len);
            dy = $rtoi(ry * 16384.0 / len);
            dz = $rtoi(rz * 16384.0 / len);
        end
        case ($urandom_range(0, 7))
            0:       rad = 0;
            1:       rad = (longint'(1) << SIZE_BITS) - 1;
            default: rad = longint'($urandom & ((1 << $urandom_range(0, 20)) - 1));
        endcase
        set_config(ox, oy, oz, dx, dy, dz, rad, $urandom_range(0, 7));
    endfunction

    // A node placed along the current ray with a random sideways offset, so
    // that cylinder membership goes both ways often.
    function automatic node_t near_ray_node();
        node_t  n;
        longint k, sc, ox, oy, oz, dx, dy, dz;
        ox = longint'($signed(cfg_next[CFG_ORIGIN_X]));
        oy = longint'($signed(cfg_next[CFG_ORIGIN_Y]));
        oz = longint'($signed(cfg_next[CFG_ORIGIN_Z]));
        dx = longint'($signed(cfg_next[CFG_DIR_X][DIR_BITS-1:0]));
        dy = longint'($signed(cfg_next[CFG_DIR_Y][DIR_BITS-1:0]));
        dz = longint'($signed(cfg_next[CFG_DIR_Z][DIR_BITS-1:0]));
        k  = longint'($urandom_range(0, 1 << $urandom_range(2, 21)));
        if ($urandom_range(0, 7) == 0)
            k = -k;
        sc      = $urandom_range(0, 20);
        n.id    = ID_BITS'($urandom);
        n.px    = COORD_BITS'(ox + (k * dx) / 16384 + rand_signed(sc));
        n.py    = COORD_BITS'(oy + (k * dy) / 16384 + rand_signed(sc));
        n.pz    = COORD_BITS'(oz + (k * dz) / 16384 + rand_signed(sc));
        n.size  = rand_size();
        n.unhl  = ($urandom_range(0, 4) == 0);
        n.lastn = 1'b0;
        return n;
    endfunction

    // Anything at all, anywhere in the coordinate range.
    function automatic node_t noise_node();
        node_t n;
        n.id    = ID_BITS'($urandom);
        n.px    = COORD_BITS'($urandom);
        n.py    = COORD_BITS'($urandom);
        n.pz    = COORD_BITS'($urandom);
        n.size  = SIZE_BITS'($urandom);
        n.unhl  = 1'($urandom_range(0, 1));
        n.lastn = 1'b0;
        return n;
    endfunction

    // Write every register from cfg_next, one per cycle; hold write high
    // across the run and drop it once at the end.
    task automatic write_config();
        for (int i = 0; i < CFG_REGS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= cfg_next[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Send one node; open a new burst with a random gap when the last one ran
    // out, then hold the transfer until the block takes it.
    task automatic send_node(input node_t n);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        node_id       <= n.id;
        pos_x         <= n.px;
        pos_y         <= n.py;
        pos_z         <= n.pz;
        node_size     <= n.size;
        unhighlighted <= n.unhl;
        last_node     <= n.lastn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input longint id, input longint x, input longint y,
                               input longint z, input longint size,
                               input bit unhl, input bit lastn);
        node_t n;
        n.id    = ID_BITS'(id);
        n.px    = COORD_BITS'(x);
        n.py    = COORD_BITS'(y);
        n.pz    = COORD_BITS'(z);
        n.size  = SIZE_BITS'(size);
        n.unhl  = unhl;
        n.lastn = lastn;
        send_node(n);
    endtask

    // Hold the sender off until every owed pick has arrived, then let the
    // back end settle for extra cycles. Sample the count at the falling edge,
    // after the watcher has finished with the rising one.
    task automatic drain_results(input int extra);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (extra + 1) @(posedge clk);
    endtask

    initial
    begin
        node_t n;
        int    items_left;
        int    count;
        int    set_left;
        int    pause_at;
        int    phase;

        sb = new();
        repeat (11) @(posedge clk);
        // release reset away from the rising edge
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset ray: origin 0, +z, radius 0, closest mode. Includes a tie on
        // the perpendicular distance, a node behind, one at the origin, a
        // skipped unhighlighted node, and a skipped node carrying last.
        send_fields(1, 512, 0, 256, 0, 0, 0);
        send_fields(2, 0, 512, 1024, 0, 0, 0);
        send_fields(3, 0, 0, -256, 0, 0, 0);
        send_fields(4, 0, 0, 0, 0, 0, 0);
        send_fields(5, 1, 0, 256, 0, 1, 0);
        send_fields(6, 100, 0, 300, 0, 1, 1);
        // a set with only a node behind: final answer with nothing found
        send_fields(7, 0, 0, -256, 0, 0, 1);
        drain_results(SETTLE_CYCLES);

        // List mode with unhighlighted included, origin at the coordinate
        // extremes, direction at its positive extreme.
        set_config(-8388608, 8388607, 0, 32767, 0, 0, 256, 5);
        write_config();
        send_fields(0, 8388607, 8388607, 0, 0, 0, 0);
        send_fields(20'hFFFFF, -8388608, 8388607, 0, 0, 0, 0);
        send_fields(20'h12345, 0, 8388607, 512, 8388607, 1, 0);
        send_fields(20'h54321, 0, -8388608, 0, 0, 0, 1);
        drain_results(SETTLE_CYCLES);

        // Mode 3 acts as nearest-in-cylinder; largest radius, negative
        // extreme direction; a tie on distance from the origin.
        set_config(0, 0, 0, -32768, -32768, -32768, 8388607, 3);
        write_config();
        send_fields(10, -1000, -1000, -1000, 0, 0, 0);
        send_fields(11, -10, -10, -10, 0, 0, 0);
        send_fields(12, -10, -10, -10, 0, 0, 0);
        send_fields(13, 8388607, 8388607, 8388607, 0, 0, 1);
        send_fields(14, 100, 0, 0, 0, 0, 1);
        drain_results(SETTLE_CYCLES);

        // Zero direction: nothing is in front.
        set_config(8388607, 8388607, -8388608, 0, 0, 0, 0, 0);
        write_config();
        send_fields(1, -8388608, -8388608, -8388608, 8388607, 0, 0);
        send_fields(2, 0, 0, 0, 0, 0, 1);
        drain_results(SETTLE_CYCLES);

        // List mode, radius 0: a near miss, then an exact hit, both carrying last
        // (member report plus final answer from one node).
        set_config(0, 0, 0, 16384, 0, 0, 0, 1);
        write_config();
        send_fields(3, 256, 1, 0, 0, 0, 1);
        send_fields(4, 256, 0, 0, 0, 0, 1);
        drain_results(SETTLE_CYCLES);

        // Random phases: new ray per phase, sets of random length, one
        // mid-phase pause until every pick is in.
        items_left = RANDOM_NODES;
        phase      = 0;
        set_left   = 0;
        while (items_left > 0)
        begin
            random_config();
            write_config();
            idle_on  = (phase % 4 != 1);
            count    = $urandom_range(40, 90);
            pause_at = $urandom_range(5, count - 5);
            for (int i = 0; i < count; i++)
            begin
                if (i == pause_at)
                    drain_results(0);
                n = ($urandom_range(0, 6) == 0) ? noise_node() : near_ray_node();
                if (set_left == 0)
                    set_left = $urandom_range(1, 12);
                set_left--;
                n.lastn = (set_left == 0) || (i == count - 1);
                if (n.lastn)
                    set_left = 0;
                send_node(n);
            end
            drain_results(SETTLE_CYCLES);
            items_left -= count;
            phase++;
        end

        sb.check_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
